FILE: rtl/mafs_pkg.sv
package mafs_pkg;

    // payload layout
    localparam int IN_FIELD_W  = 12;
    localparam int IN_DATA_W   = 40;
    localparam int IDX_W       = 5;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;
    localparam int TARGET_W    = 14;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_CHAIN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_UNSAT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_OXYGEN = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic load;
        logic sort_start;
        logic latch_key;
        logic sort_cmp;
        logic sort_write;
        logic addr_j;
        logic addr_ord;
        logic enum_start;
        logic acc;
        logic set_drop;
        logic take_match;
        logic advance;
        logic emit_final;
    } mafs_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic i_last;
        logic j_last;
        logic k_last;
        logic match;
        logic cnt_full;
        logic pend_valid;
        logic out_free;
        logic quad_last;
    } mafs_status_t;

endpackage

FILE: rtl/multi_attribute_four_sum_search.sv
// Four-sum search over three attributes. Beats with tuser=0 load one element
// (chain, unsaturation, oxygen) into the next store slot; loads past
// MAX_ELEMENTS are dropped. A beat with tuser=1 starts the search: the n
// loaded elements are stable-sorted by chain value through a rank pass over
// the single-port element memory, then the C(n+3,4) quadruples of sorted
// positions p<=q<=r<=s are visited in order, with a stall whenever a match
// waits on the result side; a match past the cap ends the scan. Each
// match gives one result beat with four 1-based load indices; one beat with
// found=0 is given when nothing matches. At most MAX_MATCHES results per
// search; tuser[1] (truncated) marks the last beat when more were dropped.
// The store empties after each search. Targets must be written through the
// cfg port only while the block is idle; the block itself does not enforce it.
module multi_attribute_four_sum_search
    import mafs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16,
    parameter int VALUE_BITS   = 12,
    parameter int MAX_MATCHES  = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // chain_value, unsat_value, oxygen_value
    input  logic                   s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // first..fourth_index
    output logic [OUT_USER_W-1:0]  m_tuser,   // found, truncated
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TARGET_W-1:0]    cfg_data
);

    mafs_cmd_t    cmd;
    mafs_status_t stat;
    logic [IDX_W-1:0] first_index, second_index, third_index, fourth_index;
    logic found, truncated;

    mafs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mafs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS),
        .MAX_MATCHES  (MAX_MATCHES)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .chain_value  (s_tdata[11:0]),
        .unsat_value  (s_tdata[23:12]),
        .oxygen_value (s_tdata[35:24]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .first_index  (first_index),
        .second_index (second_index),
        .third_index  (third_index),
        .fourth_index (fourth_index),
        .found        (found),
        .last         (m_tlast),
        .truncated    (truncated)
    );

    assign m_tdata = {4'b0, fourth_index, third_index, second_index, first_index};
    assign m_tuser = {truncated, found};

`ifndef NO_ASSERTIONS
    // a pending match is pushed out only into a free output register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_match && stat.pend_valid) |-> stat.out_free)
        else $error("match pushed over a held result");

    a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_final |-> stat.out_free)
        else $error("final result over a held result");

    // nothing is left pending once the block takes input again
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !stat.pend_valid)
        else $error("pending match while idle");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_drop |-> (stat.cnt_full && stat.match))
        else $error("drop before cap reached");
`endif

endmodule

FILE: rtl/mafs_ctrl.sv
module mafs_ctrl
    import mafs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         op,
    input  mafs_status_t stat,
    output logic         s_tready,
    output mafs_cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_SORT_RI = 12'b0000_0000_0010,
        ST_SORT_LI = 12'b0000_0000_0100,
        ST_SORT_RJ = 12'b0000_0000_1000,
        ST_SORT_CJ = 12'b0000_0001_0000,
        ST_SORT_WR = 12'b0000_0010_0000,
        ST_ENUM    = 12'b0000_0100_0000,
        ST_Q_RO    = 12'b0000_1000_0000,
        ST_Q_RA    = 12'b0001_0000_0000,
        ST_Q_ACC   = 12'b0010_0000_0000,
        ST_CHECK   = 12'b0100_0000_0000,
        ST_FINISH  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (op == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (stat.n_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.sort_start = 1'b1;
                        state_next     = ST_SORT_RI;
                    end
                end
            end
            ST_SORT_RI:
            begin
                state_next = ST_SORT_LI;
            end
            ST_SORT_LI:
            begin
                cmd.latch_key = 1'b1;
                state_next    = ST_SORT_RJ;
            end
            ST_SORT_RJ:
            begin
                cmd.addr_j = 1'b1;
                state_next = ST_SORT_CJ;
            end
            ST_SORT_CJ:
            begin
                cmd.sort_cmp = 1'b1;
                state_next   = stat.j_last ? ST_SORT_WR : ST_SORT_RJ;
            end
            ST_SORT_WR:
            begin
                cmd.sort_write = 1'b1;
                state_next     = stat.i_last ? ST_ENUM : ST_SORT_RI;
            end
            ST_ENUM:
            begin
                cmd.enum_start = 1'b1;
                state_next     = ST_Q_RO;
            end
            ST_Q_RO:
            begin
                state_next = ST_Q_RA;
            end
            ST_Q_RA:
            begin
                cmd.addr_ord = 1'b1;
                state_next   = ST_Q_ACC;
            end
            ST_Q_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.k_last ? ST_CHECK : ST_Q_RO;
            end
            ST_CHECK:
            begin
                if (stat.match && stat.cnt_full)
                begin
                    cmd.set_drop = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (!(stat.match && stat.pend_valid && !stat.out_free))
                begin
                    cmd.take_match = stat.match;
                    if (stat.quad_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_Q_RO;
                    end
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mafs_datapath.sv
module mafs_datapath
    import mafs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16,
    parameter int VALUE_BITS   = 12,
    parameter int MAX_MATCHES  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mafs_cmd_t             cmd,
    output mafs_status_t          stat,
    input  logic [IN_FIELD_W-1:0] chain_value,
    input  logic [IN_FIELD_W-1:0] unsat_value,
    input  logic [IN_FIELD_W-1:0] oxygen_value,
    input  logic                  cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TARGET_W-1:0]   cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [IDX_W-1:0]      first_index,
    output logic [IDX_W-1:0]      second_index,
    output logic [IDX_W-1:0]      third_index,
    output logic [IDX_W-1:0]      fourth_index,
    output logic                  found,
    output logic                  last,
    output logic                  truncated
);

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int NW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = $clog2(MAX_MATCHES + 1);
    localparam int VB    = VALUE_BITS;
    localparam int SUM_W = VALUE_BITS + 2;
    localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

    logic [TARGET_W-1:0] tgt_chain_reg, tgt_unsat_reg, tgt_oxy_reg;

    logic [3*VB-1:0] attr_mem [MAX_ELEMENTS];
    logic [AW-1:0]   order_mem [MAX_ELEMENTS];
    logic [3*VB-1:0] attr_rd_reg;
    logic [AW-1:0]   order_rd_reg;
    logic [AW-1:0]   attr_raddr;

    logic [NW-1:0] count_reg;
    logic [AW-1:0] i_reg, j_reg, rank_reg;
    logic [VB-1:0] key_reg;

    logic [AW-1:0] p_reg, q_reg, r_reg, s_reg, pos_k;
    logic [1:0]    k_reg;
    logic [SUM_W-1:0] sum_c_reg, sum_u_reg, sum_o_reg;
    logic [IDX_W-1:0] idx_reg [4];
    logic [IDX_W-1:0] pend_reg [4];
    logic             pend_valid_reg;
    logic [CW-1:0]    match_cnt_reg;
    logic             drop_reg;

    logic [IDX_W-1:0] out_idx_reg [4];
    logic             out_valid_reg, out_found_reg, out_last_reg, out_trunc_reg;

    logic out_free, less;

    function automatic logic at_end(input logic [AW-1:0] x, input logic [NW-1:0] n);
        at_end = ({1'b0, x} + NW'(1)) == n;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_chain_reg <= '0;
            tgt_unsat_reg <= '0;
            tgt_oxy_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_CHAIN:  tgt_chain_reg <= cfg_data;
                REG_TARGET_UNSAT:  tgt_unsat_reg <= cfg_data;
                REG_TARGET_OXYGEN: tgt_oxy_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // element and order stores
    always_comb
    begin
        if (cmd.addr_j)
            attr_raddr = j_reg;
        else if (cmd.addr_ord)
            attr_raddr = order_rd_reg;
        else
            attr_raddr = i_reg;
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    pos_k = p_reg;
            2'd1:    pos_k = q_reg;
            2'd2:    pos_k = r_reg;
            default: pos_k = s_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < NW'(MAX_ELEMENTS)))
        begin
            attr_mem[count_reg[AW-1:0]] <= {VB'(oxygen_value), VB'(unsat_value),
                                            VB'(chain_value)};
        end
        attr_rd_reg <= attr_mem[attr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_write)
        begin
            order_mem[rank_reg] <= i_reg;
        end
        order_rd_reg <= order_mem[pos_k];
    end

    // stable rank: earlier loads win ties
    assign less = (attr_rd_reg[VB-1:0] < key_reg) ||
                  ((attr_rd_reg[VB-1:0] == key_reg) && (j_reg < i_reg));

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            match_cnt_reg  <= '0;
            drop_reg       <= 1'b0;
            k_reg          <= '0;
        end
        else
        begin
            if (cmd.load && (count_reg < NW'(MAX_ELEMENTS)))
                count_reg <= count_reg + NW'(1);
            if (cmd.emit_final || (cmd.take_match && pend_valid_reg))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.enum_start)
            begin
                pend_valid_reg <= 1'b0;
                match_cnt_reg  <= '0;
                drop_reg       <= 1'b0;
                k_reg          <= '0;
            end
            if (cmd.acc)
                k_reg <= k_reg + 2'd1;
            if (cmd.set_drop)
                drop_reg <= 1'b1;
            if (cmd.take_match)
            begin
                pend_valid_reg <= 1'b1;
                match_cnt_reg  <= match_cnt_reg + CW'(1);
            end
            if (cmd.emit_final)
            begin
                pend_valid_reg <= 1'b0;
                drop_reg       <= 1'b0;
                count_reg      <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_start)
            i_reg <= '0;
        if (cmd.latch_key)
        begin
            key_reg  <= attr_rd_reg[VB-1:0];
            j_reg    <= '0;
            rank_reg <= '0;
        end
        if (cmd.sort_cmp)
        begin
            j_reg <= j_reg + AW'(1);
            if (less)
                rank_reg <= rank_reg + AW'(1);
        end
        if (cmd.sort_write)
            i_reg <= i_reg + AW'(1);

        if (cmd.enum_start)
        begin
            p_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            sum_c_reg <= '0;
            sum_u_reg <= '0;
            sum_o_reg <= '0;
        end
        if (cmd.acc)
        begin
            sum_c_reg <= sum_c_reg + SUM_W'(attr_rd_reg[VB-1:0]);
            sum_u_reg <= sum_u_reg + SUM_W'(attr_rd_reg[2*VB-1:VB]);
            sum_o_reg <= sum_o_reg + SUM_W'(attr_rd_reg[3*VB-1:2*VB]);
            idx_reg[k_reg] <= IDX_W'(order_rd_reg) + IDX_W'(1);
        end
        if (cmd.advance)
        begin
            sum_c_reg <= '0;
            sum_u_reg <= '0;
            sum_o_reg <= '0;
            if (!at_end(s_reg, count_reg))
            begin
                s_reg <= s_reg + AW'(1);
            end
            else if (!at_end(r_reg, count_reg))
            begin
                r_reg <= r_reg + AW'(1);
                s_reg <= r_reg + AW'(1);
            end
            else if (!at_end(q_reg, count_reg))
            begin
                q_reg <= q_reg + AW'(1);
                r_reg <= q_reg + AW'(1);
                s_reg <= q_reg + AW'(1);
            end
            else
            begin
                p_reg <= p_reg + AW'(1);
                q_reg <= p_reg + AW'(1);
                r_reg <= p_reg + AW'(1);
                s_reg <= p_reg + AW'(1);
            end
        end
        if (cmd.take_match)
        begin
            pend_reg <= idx_reg;
            if (pend_valid_reg)
            begin
                out_idx_reg   <= pend_reg;
                out_found_reg <= 1'b1;
                out_last_reg  <= 1'b0;
                out_trunc_reg <= 1'b0;
            end
        end
        if (cmd.emit_final)
        begin
            out_last_reg  <= 1'b1;
            out_found_reg <= pend_valid_reg;
            out_trunc_reg <= drop_reg;
            for (int f = 0; f < 4; f++)
                out_idx_reg[f] <= pend_valid_reg ? pend_reg[f] : '0;
        end
    end

    always_comb
    begin
        stat.n_zero     = (count_reg == '0);
        stat.i_last     = at_end(i_reg, count_reg);
        stat.j_last     = at_end(j_reg, count_reg);
        stat.k_last     = (k_reg == 2'd3);
        stat.match      = (CMP_W'(sum_c_reg) == CMP_W'(tgt_chain_reg)) &&
                          (CMP_W'(sum_u_reg) == CMP_W'(tgt_unsat_reg)) &&
                          (CMP_W'(sum_o_reg) == CMP_W'(tgt_oxy_reg));
        stat.cnt_full   = (match_cnt_reg == CW'(MAX_MATCHES));
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
        stat.quad_last  = at_end(p_reg, count_reg);
    end

    assign m_tvalid     = out_valid_reg;
    assign first_index  = out_idx_reg[0];
    assign second_index = out_idx_reg[1];
    assign third_index  = out_idx_reg[2];
    assign fourth_index = out_idx_reg[3];
    assign found        = out_found_reg;
    assign last         = out_last_reg;
    assign truncated    = out_trunc_reg;

endmodule

FILE: dv/multi_attribute_four_sum_search_tb.sv
`timescale 1ns / 100ps

module multi_attribute_four_sum_search_tb;
    import mafs_pkg::*;

    localparam int STORE_DEPTH = 16;
    localparam int RESULT_CAP  = 64;

    typedef struct packed {
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] second_idx;
        logic [IDX_W-1:0] third_idx;
        logic [IDX_W-1:0] fourth_idx;
        logic             found;
        logic             last;
        logic             truncated;
    } quad_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TARGET_W-1:0]    cfg_data;

    // shadow of the block's store and targets
    logic [IN_FIELD_W-1:0] chain_mem [STORE_DEPTH];
    logic [IN_FIELD_W-1:0] unsat_mem [STORE_DEPTH];
    logic [IN_FIELD_W-1:0] oxy_mem [STORE_DEPTH];
    int                    loaded;
    logic [TARGET_W-1:0]   want_chain, want_unsat, want_oxy;

    quad_t pending_quads[$];
    int    errors;
    int    sent_items;
    int    burst_left;
    int    hold_off;

    // staging for one element set
    logic [IN_FIELD_W-1:0] set_c [20];
    logic [IN_FIELD_W-1:0] set_u [20];
    logic [IN_FIELD_W-1:0] set_o [20];

    multi_attribute_four_sum_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // stable sort by chain, then p<=q<=r<=s scan until a match past the cap
    task automatic search_quads();
        int    ord [STORE_DEPTH];
        int    i, j, key, p, q, r, s, hits;
        bit    dropped;
        quad_t qd;
        begin
            for (i = 0; i < loaded; i++)
                ord[i] = i;
            for (i = 1; i < loaded; i++)
            begin
                key = ord[i];
                j = i;
                while (j > 0 && chain_mem[ord[j-1]] > chain_mem[key])
                begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = key;
            end
            hits = 0;
            dropped = 0;
            for (p = 0; p < loaded && !dropped; p++)
                for (q = p; q < loaded && !dropped; q++)
                    for (r = q; r < loaded && !dropped; r++)
                        for (s = r; s < loaded && !dropped; s++)
                        begin
                            if (32'(chain_mem[ord[p]]) + chain_mem[ord[q]] + chain_mem[ord[r]]
                                + chain_mem[ord[s]] != 32'(want_chain))
                                continue;
                            if (32'(unsat_mem[ord[p]]) + unsat_mem[ord[q]] + unsat_mem[ord[r]]
                                + unsat_mem[ord[s]] != 32'(want_unsat))
                                continue;
                            if (32'(oxy_mem[ord[p]]) + oxy_mem[ord[q]] + oxy_mem[ord[r]]
                                + oxy_mem[ord[s]] != 32'(want_oxy))
                                continue;
                            if (hits >= RESULT_CAP)
                            begin
                                dropped = 1;
                                continue;
                            end
                            qd.first_idx  = IDX_W'(ord[p] + 1);
                            qd.second_idx = IDX_W'(ord[q] + 1);
                            qd.third_idx  = IDX_W'(ord[r] + 1);
                            qd.fourth_idx = IDX_W'(ord[s] + 1);
                            qd.found      = 1'b1;
                            qd.last       = 1'b0;
                            qd.truncated  = 1'b0;
                            pending_quads = {pending_quads, qd};
                            hits++;
                        end
            if (hits == 0)
            begin
                qd = '{'0, '0, '0, '0, 1'b0, 1'b1, 1'b0};
                pending_quads = {pending_quads, qd};
            end
            else
            begin
                pending_quads[$].last      = 1'b1;
                pending_quads[$].truncated = dropped;
            end
            loaded = 0;
        end
    endtask

    // one beat, with burst/gap shaping on the sender side
    task automatic send_beat(input logic op, input logic [IN_FIELD_W-1:0] c,
                             input logic [IN_FIELD_W-1:0] u, input logic [IN_FIELD_W-1:0] o);
        int gap;
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {4'b0, o, u, c};
            do
                @(posedge clk);
            while (!s_tready);
            sent_items++;
            if (op == OP_START)
                search_quads();
            else if (loaded < STORE_DEPTH)
            begin
                chain_mem[loaded] = c;
                unsat_mem[loaded] = u;
                oxy_mem[loaded]   = o;
                loaded++;
            end
        end
    endtask

    // wait out all results, then let the block settle before touching targets
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            wait (pending_quads.size() == 0);
            repeat (30) @(posedge clk);
        end
    endtask

    task automatic write_targets(input logic [TARGET_W-1:0] c, input logic [TARGET_W-1:0] u,
                                 input logic [TARGET_W-1:0] o);
        begin
            drain();
            @(posedge clk);
            cfg_we <= 1'b1; cfg_index <= REG_TARGET_CHAIN; cfg_data <= c;
            @(posedge clk);
            cfg_index <= REG_TARGET_UNSAT; cfg_data <= u;
            @(posedge clk);
            cfg_index <= REG_TARGET_OXYGEN; cfg_data <= o;
            @(posedge clk);
            cfg_we <= 1'b0;
            want_chain = c;
            want_unsat = u;
            want_oxy   = o;
        end
    endtask

    task automatic send_set(input int n);
        begin
            for (int i = 0; i < n; i++)
                send_beat(OP_LOAD, set_c[i], set_u[i], set_o[i]);
            send_beat(OP_START, IN_FIELD_W'($urandom), IN_FIELD_W'($urandom),
                      IN_FIELD_W'($urandom));
        end
    endtask

    task automatic fill_set(input int n, input logic [IN_FIELD_W-1:0] c,
                            input logic [IN_FIELD_W-1:0] u, input logic [IN_FIELD_W-1:0] o);
        begin
            for (int i = 0; i < n; i++)
            begin
                set_c[i] = c; set_u[i] = u; set_o[i] = o;
            end
        end
    endtask

    task automatic test_empty_store();
        begin
            write_targets(0, 0, 0);
            send_set(0);
        end
    endtask

    task automatic test_zero_element();
        begin
            fill_set(1, 0, 0, 0);
            send_set(1);
        end
    endtask

    task automatic test_max_values();
        begin
            write_targets(16380, 16380, 16380);
            fill_set(2, 12'hfff, 12'hfff, 12'hfff);
            set_c[1] = 12'hffe;
            send_set(2);
            write_targets(14'h3fff, 14'h3fff, 14'h3fff);
            fill_set(3, 12'hfff, 12'hfff, 12'hfff);
            send_set(3);
        end
    endtask

    // equal chain keys: order must follow load order
    task automatic test_chain_ties();
        begin
            write_targets(40, 10, 8);
            fill_set(5, 10, 0, 2);
            set_u[1] = 10; set_u[3] = 5; set_u[4] = 5;
            set_c[2] = 5;  set_c[0] = 15; set_u[0] = 0;
            send_set(5);
        end
    endtask

    // 18 loads into a 16-deep store, all identical: cap and truncation
    task automatic test_store_full();
        begin
            write_targets(4, 8, 12);
            fill_set(18, 1, 2, 3);
            send_set(18);
        end
    endtask

    // receiver holds off while the sender keeps offering the next set
    task automatic test_backpressure();
        begin
            write_targets(0, 0, 0);
            fill_set(8, 0, 0, 0);
            send_set(8);
            hold_off = 3000;
            fill_set(4, 0, 0, 0);
            send_set(4);
        end
    endtask

    task automatic test_random_sets();
        int n, mode, pick;
        logic [TARGET_W-1:0] tc, tu, tx;
        begin
            while (sent_items < 320)
            begin
                mode = $urandom_range(0, 9);
                n = (mode == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                begin
                    if (mode < 5)
                    begin
                        set_c[i] = IN_FIELD_W'($urandom_range(0, 3));
                        set_u[i] = IN_FIELD_W'($urandom_range(0, 3));
                        set_o[i] = IN_FIELD_W'($urandom_range(0, 3));
                    end
                    else
                    begin
                        set_c[i] = IN_FIELD_W'($urandom);
                        set_u[i] = IN_FIELD_W'($urandom);
                        set_o[i] = IN_FIELD_W'($urandom);
                    end
                end
                if (n == 0 || mode == 9)
                begin
                    tc = TARGET_W'($urandom); tu = TARGET_W'($urandom); tx = TARGET_W'($urandom);
                end
                else
                begin
                    tc = '0; tu = '0; tx = '0;
                    for (int k = 0; k < 4; k++)
                    begin
                        pick = $urandom_range(0, (n > STORE_DEPTH ? STORE_DEPTH : n) - 1);
                        tc = tc + TARGET_W'(set_c[pick]);
                        tu = tu + TARGET_W'(set_u[pick]);
                        tx = tx + TARGET_W'(set_o[pick]);
                    end
                end
                write_targets(tc, tu, tx);
                send_set(n);
            end
        end
    endtask

    // receiver stall pattern, with long hold-offs on request
    int ready_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                ready_mode <= $urandom_range(0, 3);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
        end
    end

    always @(posedge clk)
    begin
        quad_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_quads.size() == 0)
            begin
                $error("unexpected result beat tdata=%h tuser=%b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = pending_quads.pop_front();
                if (m_tdata[4:0] !== want.first_idx)
                begin
                    $error("first_index exp %0d got %0d", want.first_idx, m_tdata[4:0]);
                    errors++;
                end
                if (m_tdata[9:5] !== want.second_idx)
                begin
                    $error("second_index exp %0d got %0d", want.second_idx, m_tdata[9:5]);
                    errors++;
                end
                if (m_tdata[14:10] !== want.third_idx)
                begin
                    $error("third_index exp %0d got %0d", want.third_idx, m_tdata[14:10]);
                    errors++;
                end
                if (m_tdata[19:15] !== want.fourth_idx)
                begin
                    $error("fourth_index exp %0d got %0d", want.fourth_idx, m_tdata[19:15]);
                    errors++;
                end
                if (m_tuser[0] !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last exp %0d got %0d", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser[1] !== want.truncated)
                begin
                    $error("truncated exp %0d got %0d", want.truncated, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        errors = 0; sent_items = 0; burst_left = 0; hold_off = 0; loaded = 0;
        want_chain = 0; want_unsat = 0; want_oxy = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_LOAD;
        cfg_we = 1'b0; cfg_index = REG_TARGET_CHAIN; cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_zero_element();
        test_max_values();
        test_chain_ties();
        test_store_full();
        test_backpressure();
        test_random_sets();

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
